[rtl/cft_pkg.sv]
`timescale 1ns / 1ps
package cft_pkg;

  localparam int HOLD_DEPTH = 16;
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int ADDR_W     = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CHAR_W     = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd44;
  localparam logic [CHAR_W-1:0] QUOTE_RESET = 8'd34;

  localparam logic [APB_ADDR_W-1:0] REG_DELIM = 3'd0;
  localparam logic [APB_ADDR_W-1:0] REG_QUOTE = 3'd4;

  typedef enum logic [1:0] {
    MODE_OUT  = 2'd0,
    MODE_IN   = 2'd1,
    MODE_PEND = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SRC_DIRECT = 2'd0,
    SRC_HELD   = 2'd1,
    SRC_PEND   = 2'd2
  } src_e;

  typedef struct packed {
    logic in_ready;
    logic out_load;
    src_e src;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  typedef struct packed {
    logic  item_valid;
    kind_e kind;
    logic  has_held;
    logic  idx_last;
    logic  slot_free;
  } sts_t;

  typedef struct packed {
    logic              we_delim;
    logic              we_quote;
    logic [CHAR_W-1:0] wdata;
  } cfg_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'd133 || c == 8'd160;
  endfunction

endpackage

[rtl/cft_if.sv]
`timescale 1ns / 1ps
interface cft_item_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] ch;

  modport source (output valid, output action, output ch, input ready);
  modport sink (input valid, input action, input ch, output ready);
endinterface

interface cft_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       field_end;
  logic       line_end;
  logic       ws_overflow;
  logic       last;

  modport source (output valid, output out_char, output has_char, output field_end,
                  output line_end, output ws_overflow, output last, input ready);
  modport sink (input valid, input out_char, input has_char, input field_end,
                input line_end, input ws_overflow, input last, output ready);
endinterface

[rtl/csv_field_tokenizer.sv]
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// item_i    in   valid/ready        action, ch
// result_o  out  valid/ready        out_char, has_char, field_end, line_end,
//                                   ws_overflow, last
// apb       in   psel/penable/pwr   paddr[2:0], pwdata, prdata (pready tied high)
//
// An item with zero or one result is taken in the idle state. An item that
// releases held whitespace chars starts a drain: each held char is one read of
// the hold RAM (registered read) plus one output load, then the char itself.
// Async active-low reset; the hold RAM is not cleared and needs no sweep.
// A stalled result register holds off new items and the drain sequencer.
module csv_field_tokenizer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  cft_item_if.sink                           item_i,
  cft_result_if.source                       result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cft_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [cft_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cft_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);
  import cft_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  cfg_t              cfg;
  logic [CHAR_W-1:0] delim, quote;
  logic              apb_wr;

  assign pready   = 1'b1;
  assign apb_wr   = psel && penable && pwrite;
  assign cfg.we_delim = apb_wr && (paddr[2] == REG_DELIM[2]);
  assign cfg.we_quote = apb_wr && (paddr[2] == REG_QUOTE[2]);
  assign cfg.wdata    = pwdata[CHAR_W-1:0];
  assign prdata = {{(APB_DATA_W-CHAR_W){1'b0}},
                   ((paddr[2] == REG_QUOTE[2]) ? quote : delim)};

  cft_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cft_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item    (item_i),
    .result  (result_o),
    .cfg_i   (cfg),
    .delim_o (delim),
    .quote_o (quote),
    .cmd_i   (cmd),
    .sts_o   (sts)
  );

`ifndef SYNTHESIS
  a_no_char_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.has_char |-> result_o.field_end && result_o.last)
    else $error("empty result is not a final field end");

  a_line_end_ends_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.line_end |-> result_o.field_end && !result_o.has_char)
    else $error("line end without field end");

  a_eol_gives_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready && item_i.action |=>
      result_o.valid && result_o.field_end && result_o.line_end)
    else $error("end of line item did not produce a line end");

  a_drain_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.idx_inc || cmd.src == SRC_PEND |-> !item_i.ready)
    else $error("item taken while held chars drain");
`endif

endmodule

[rtl/cft_ram.sv]
`timescale 1ns / 1ps
module cft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/cft_ctrl.sv]
`timescale 1ns / 1ps
module cft_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cft_pkg::sts_t sts_i,
  output cft_pkg::cmd_t cmd_o
);
  import cft_pkg::*;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_DRAIN_RD  = 2'd1;
  localparam logic [1:0] ST_DRAIN_OUT = 2'd2;
  localparam logic [1:0] ST_FINAL     = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.src     = SRC_DIRECT;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = sts_i.slot_free;
        if (sts_i.item_valid && sts_i.slot_free) begin
          if (sts_i.kind == KIND_CHAR && sts_i.has_held) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_DRAIN_RD;
          end else if (sts_i.kind != KIND_NONE) begin
            cmd_o.out_load = 1'b1;
          end
        end
      end
      ST_DRAIN_RD: begin
        state_d = ST_DRAIN_OUT;
      end
      ST_DRAIN_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.src      = SRC_HELD;
          if (sts_i.idx_last) begin
            state_d = ST_FINAL;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_DRAIN_RD;
          end
        end
      end
      ST_FINAL: begin
        if (sts_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.src      = SRC_PEND;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/cft_dp.sv]
`timescale 1ns / 1ps
module cft_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cft_item_if.sink                      item,
  cft_result_if.source                  result,
  input  cft_pkg::cfg_t                 cfg_i,
  output logic [cft_pkg::CHAR_W-1:0]    delim_o,
  output logic [cft_pkg::CHAR_W-1:0]    quote_o,
  input  cft_pkg::cmd_t                 cmd_i,
  output cft_pkg::sts_t                 sts_o
);
  import cft_pkg::*;

  logic [CHAR_W-1:0] delim_q, quote_q;
  mode_e             mode_q, mode_d;
  logic              started_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  idx_q;
  logic [CNT_W-1:0]  drain_cnt_q;
  logic [CHAR_W-1:0] pend_q;

  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              has_char_q, field_end_q, line_end_q, ws_ovf_q, last_q;

  logic              accept;
  kind_e             kind;
  logic              end_le;
  logic              content, fall;
  logic              ws_wr, ovf_set;
  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] held_rdata;

  assign c      = item.ch;
  assign accept = item.valid && cmd_i.in_ready;

  always_comb begin
    mode_d  = mode_q;
    kind    = KIND_NONE;
    end_le  = 1'b0;
    content = 1'b0;
    fall    = 1'b0;
    ws_wr   = 1'b0;
    ovf_set = 1'b0;
    if (item.action) begin
      mode_d = MODE_OUT;
      kind   = KIND_END;
      end_le = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_PEND: begin
          if (c == quote_q) begin
            mode_d  = MODE_IN;
            content = 1'b1;
          end else begin
            fall = 1'b1;
          end
        end
        MODE_IN: begin
          if (c == quote_q) begin
            mode_d = MODE_PEND;
          end else begin
            content = 1'b1;
          end
        end
        default: fall = 1'b1;
      endcase
      if (fall) begin
        mode_d = MODE_OUT;
        priority if (c == quote_q) begin
          mode_d = MODE_IN;
        end else if (c == delim_q) begin
          kind = KIND_END;
        end else begin
          content = 1'b1;
        end
      end
      if (content) begin
        if (is_ws(c)) begin
          if (started_q && cnt_q < CNT_W'(HOLD_DEPTH)) begin
            ws_wr = 1'b1;
          end else if (started_q) begin
            ovf_set = 1'b1;
          end
        end else begin
          kind = KIND_CHAR;
        end
      end
    end
  end

  cft_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (accept && ws_wr),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (c),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (held_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q     <= DELIM_RESET;
      quote_q     <= QUOTE_RESET;
      mode_q      <= MODE_OUT;
      started_q   <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we_delim) begin
        delim_q <= cfg_i.wdata;
      end
      if (cfg_i.we_quote) begin
        quote_q <= cfg_i.wdata;
      end
      if (accept) begin
        mode_q <= mode_d;
        if (kind == KIND_END) begin
          started_q <= 1'b0;
          cnt_q     <= '0;
          ovf_q     <= 1'b0;
        end else if (kind == KIND_CHAR) begin
          started_q <= 1'b1;
          cnt_q     <= '0;
        end else if (ws_wr) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end else if (ovf_set) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (result.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind == KIND_CHAR) begin
      drain_cnt_q <= cnt_q;
      pend_q      <= c;
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.src)
        SRC_HELD: begin
          out_char_q  <= held_rdata;
          has_char_q  <= 1'b1;
          field_end_q <= 1'b0;
          line_end_q  <= 1'b0;
          ws_ovf_q    <= 1'b0;
          last_q      <= 1'b0;
        end
        SRC_PEND: begin
          out_char_q  <= pend_q;
          has_char_q  <= 1'b1;
          field_end_q <= 1'b0;
          line_end_q  <= 1'b0;
          ws_ovf_q    <= 1'b0;
          last_q      <= 1'b1;
        end
        default: begin
          if (kind == KIND_CHAR) begin
            out_char_q  <= c;
            has_char_q  <= 1'b1;
            field_end_q <= 1'b0;
            line_end_q  <= 1'b0;
            ws_ovf_q    <= 1'b0;
          end else begin
            out_char_q  <= '0;
            has_char_q  <= 1'b0;
            field_end_q <= 1'b1;
            line_end_q  <= end_le;
            ws_ovf_q    <= ovf_q;
          end
          last_q <= 1'b1;
        end
      endcase
    end
  end

  assign item.ready         = cmd_i.in_ready;
  assign result.valid       = out_valid_q;
  assign result.out_char    = out_char_q;
  assign result.has_char    = has_char_q;
  assign result.field_end   = field_end_q;
  assign result.line_end    = line_end_q;
  assign result.ws_overflow = ws_ovf_q;
  assign result.last        = last_q;

  assign delim_o = delim_q;
  assign quote_o = quote_q;

  assign sts_o.item_valid = item.valid;
  assign sts_o.kind       = kind;
  assign sts_o.has_held   = (cnt_q != '0);
  assign sts_o.idx_last   = ((idx_q + CNT_W'(1)) == drain_cnt_q);
  assign sts_o.slot_free  = !out_valid_q || result.ready;

endmodule
